>>> design/hrlp_pkg.sv
// types, constants and the per-byte classifier of the request line parser
// used by hrlp_out_fifo and http_request_line_parser; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package hrlp_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int LEN_WIDTH    = 16;
   localparam int DIGIT_WIDTH  = 4;
   localparam int VLEN_WIDTH   = 4;
   localparam int FIFO_PTR_W   = 2;
   localparam int FIFO_DEPTH   = 1 << FIFO_PTR_W;
   localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [LEN_WIDTH-1:0]   len_type;
   typedef logic [DIGIT_WIDTH-1:0] digit_type;
   typedef logic [VLEN_WIDTH-1:0]  vlen_type;

   localparam len_type  LEN_MAX     = '1;
   localparam vlen_type VLEN_MAX    = '1;
   localparam vlen_type VERSION_LEN = vlen_type'(8);

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_H     = 8'h48;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_P     = 8'h50;

   typedef enum logic [1:0] {
      CSR_MAJOR     = 2'd0,
      CSR_CUR_MINOR = 2'd1,
      CSR_LEG_MINOR = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ROLE_METHOD  = 3'd0,
      ROLE_SPACE   = 3'd1,
      ROLE_PATH    = 3'd2,
      ROLE_QMARK   = 3'd3,
      ROLE_QUERY   = 3'd4,
      ROLE_VERSION = 3'd5,
      ROLE_END     = 3'd6
   } role_type;

   typedef enum logic [1:0] {
      ST_PROGRESS    = 2'd0,
      ST_OK          = 2'd1,
      ST_BAD         = 2'd2,
      ST_UNSUPPORTED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_METHOD  = 2'd0,
      PH_TARGET  = 2'd1,
      PH_VERSION = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      empty;
      logic      query;
      logic      bad;
      vlen_type  vlen;
      logic      shape_ok;
      digit_type major;
      digit_type minor;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      phase: PH_METHOD, empty: 1'b1, query: 1'b0, bad: 1'b0, vlen: '0,
      shape_ok: 1'b1, major: '0, minor: '0};

   typedef struct packed {
      parse_state_type st;
      role_type        role;
   } step_type;

   typedef struct packed {
      logic       last;
      len_type    length;
      status_type status;
      logic       done;
      role_type   role;
      logic [7:0] data;
   } rsp_item_type;

   typedef struct packed {
      logic         valid0;
      logic         valid1;
      rsp_item_type item0;
      rsp_item_type item1;
   } fifo_push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_0) && (c <= CHAR_9);
   endfunction

   function automatic logic [7:0] prefix_char(input vlen_type pos);
      logic [7:0] ch;
      case (pos)
         vlen_type'(0): ch = CHAR_H;
         vlen_type'(1): ch = CHAR_T;
         vlen_type'(2): ch = CHAR_T;
         vlen_type'(3): ch = CHAR_P;
         default:       ch = CHAR_SLASH;
      endcase
      return ch;
   endfunction

   function automatic count_type count_sat(input count_type c);
      return (c != '1) ? count_type'(c + 1'b1) : c;
   endfunction

   function automatic len_type clamp_length(input count_type c);
      return (c > count_type'(LEN_MAX)) ? LEN_MAX : len_type'(c);
   endfunction

   // tag one field byte and update the parse flags
   function automatic step_type field_step(input parse_state_type s, input logic [7:0] c);
      step_type   r;
      logic [7:0] d;
      r = '{st: s, role: ROLE_VERSION};
      d = c - CHAR_0;
      case (s.phase)
         PH_METHOD: begin
            if (c == CHAR_SPACE) begin
               r.st.bad   = s.bad | s.empty;
               r.st.phase = PH_TARGET;
               r.st.empty = 1'b1;
               r.role     = ROLE_SPACE;
            end else begin
               if ((c < CHAR_A) || (c > CHAR_Z)) r.st.bad = 1'b1;
               r.st.empty = 1'b0;
               r.role     = ROLE_METHOD;
            end
         end
         PH_TARGET: begin
            if (c == CHAR_SPACE) begin
               r.st.bad   = s.bad | s.empty;
               r.st.phase = PH_VERSION;
               r.st.empty = 1'b1;
               r.role     = ROLE_SPACE;
            end else begin
               if (s.empty && (c != CHAR_SLASH)) r.st.bad = 1'b1;
               r.st.empty = 1'b0;
               if (!s.query && (c == CHAR_QMARK)) begin
                  r.st.query = 1'b1;
                  r.role     = ROLE_QMARK;
               end else begin
                  r.role = s.query ? ROLE_QUERY : ROLE_PATH;
               end
            end
         end
         default: begin
            if (c == CHAR_SPACE) begin
               r.st.bad = 1'b1;
               r.role   = ROLE_SPACE;
            end
            if (s.vlen < vlen_type'(5)) begin
               if (c != prefix_char(s.vlen)) r.st.shape_ok = 1'b0;
            end else if (s.vlen == vlen_type'(5)) begin
               if (is_digit(c)) r.st.major = d[DIGIT_WIDTH-1:0];
               else r.st.shape_ok = 1'b0;
            end else if (s.vlen == vlen_type'(6)) begin
               if (c != CHAR_DOT) r.st.shape_ok = 1'b0;
            end else if (s.vlen == vlen_type'(7)) begin
               if (is_digit(c)) r.st.minor = d[DIGIT_WIDTH-1:0];
               else r.st.shape_ok = 1'b0;
            end else begin
               r.st.shape_ok = 1'b0;
            end
            if (s.vlen != VLEN_MAX) r.st.vlen = vlen_type'(s.vlen + 1'b1);
            r.st.empty = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic status_type line_verdict(input parse_state_type s,
                                               input digit_type major_cfg,
                                               input digit_type cur_cfg,
                                               input digit_type leg_cfg);
      status_type v;
      if ((s.phase == PH_METHOD) || (s.phase == PH_TARGET) || s.bad) v = ST_BAD;
      else if ((s.vlen != VERSION_LEN) || !s.shape_ok) v = ST_BAD;
      else if ((s.major == major_cfg) && ((s.minor == cur_cfg) || (s.minor == leg_cfg)))
         v = ST_OK;
      else v = ST_UNSUPPORTED;
      return v;
   endfunction

endpackage
`default_nettype wire

>>> design/hrlp_out_fifo.sv
// result queue of the request line parser: up to two items in, and one item out
// per cycle while rd_ready is high; depends on hrlp_pkg
`timescale 1ns / 1ps
`default_nettype none
module hrlp_out_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hrlp_pkg::fifo_push_type push,
   output logic                        free_two,
   output logic                        rd_valid,
   input  wire logic                   rd_ready,
   output hrlp_pkg::rsp_item_type      rd_item
);
   import hrlp_pkg::*;

   rsp_item_type            mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [FIFO_CNT_W-1:0]   n_wr;
   logic                    pop;

   always_comb begin
      n_wr      = FIFO_CNT_W'(push.valid0) + FIFO_CNT_W'(push.valid1);
      pop       = rd_valid & rd_ready;
      count_in  = count_ff + n_wr - FIFO_CNT_W'(pop);
      wr_ptr_in = wr_ptr_ff + n_wr[FIFO_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   end

   assign rd_valid = (count_ff != '0);
   assign free_two = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign rd_item  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) mem[wr_ptr_ff] <= push.item0;
      if (push.valid1) mem[FIFO_PTR_W'(wr_ptr_ff + 1'b1)] <= push.item1;
   end

endmodule
`default_nettype wire

>>> design/http_request_line_parser.sv
// top level of the request line parser: byte tagging, line verdict, csr port
// depends on hrlp_pkg and hrlp_out_fifo
//
//  channel  direction  handshake               payload
//  req      in         req_tvalid/req_tready   tdata: data_byte
//  rsp      out        rsp_tvalid/rsp_tready   tdata, tuser, tlast (see ports)
//  csr      in         psel/penable, pready=1  three 4-bit digit registers
//
// one byte is taken per cycle while req_tready is high and parsed in the cycle it is accepted;
// its items land in a four-entry result queue and leave one per cycle while rsp_tready is high.
// a byte other than CR or LF that follows a held CR makes two items; req_tready drops while the
// queue has fewer than two free entries, so output bandwidth sets the rate then.
// synchronous reset clears the parse state and the queue and loads the registers with 1, 1, 0.
`timescale 1ns / 1ps
`default_nettype none
module http_request_line_parser (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,  // [7:0] data_byte
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [31:0]                           rsp_tdata,  // [7:0] out_byte, [9:8] line_status,
                                                             // [25:10] line_length, rest zero
   output logic [3:0]                            rsp_tuser,  // [2:0] byte_role, [3] line_done
   output logic                                  rsp_tlast,  // last_of_run
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [hrlp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [hrlp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [hrlp_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import hrlp_pkg::*;

   digit_type       major_cfg_ff, cur_cfg_ff, leg_cfg_ff;
   parse_state_type pst_ff, pst_in;
   logic            cr_held_ff, cr_held_in;
   count_type       count_ff, count_in;
   fifo_push_type   push;
   step_type        r1, r2;
   rsp_item_type    rsp_item;
   logic            accept;
   logic            csr_wr;
   csr_index_type   csr_idx;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      case (csr_idx)
         CSR_MAJOR:     csr_prdata = CSR_DATA_W'(major_cfg_ff);
         CSR_CUR_MINOR: csr_prdata = CSR_DATA_W'(cur_cfg_ff);
         CSR_LEG_MINOR: csr_prdata = CSR_DATA_W'(leg_cfg_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         major_cfg_ff <= digit_type'(1);
         cur_cfg_ff   <= digit_type'(1);
         leg_cfg_ff   <= digit_type'(0);
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_MAJOR:     major_cfg_ff <= csr_pwdata[DIGIT_WIDTH-1:0];
            CSR_CUR_MINOR: cur_cfg_ff   <= csr_pwdata[DIGIT_WIDTH-1:0];
            CSR_LEG_MINOR: leg_cfg_ff   <= csr_pwdata[DIGIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // per-byte parse
   assign accept = req_tvalid & req_tready;

   always_comb begin
      pst_in     = pst_ff;
      cr_held_in = cr_held_ff;
      count_in   = count_ff;
      push       = '0;
      r1         = field_step(pst_ff, CHAR_CR);
      r2         = field_step(cr_held_ff ? r1.st : pst_ff, req_tdata);
      if (accept) begin
         if (cr_held_ff && (req_tdata == CHAR_LF)) begin
            count_in           = count_sat(count_ff);
            push.valid0        = 1'b1;
            push.item0.data    = req_tdata;
            push.item0.role    = ROLE_END;
            push.item0.done    = 1'b1;
            push.item0.status  = line_verdict(pst_ff, major_cfg_ff, cur_cfg_ff, leg_cfg_ff);
            push.item0.length  = clamp_length(count_in);
            push.item0.last    = 1'b1;
            pst_in             = PARSE_RESET;
            cr_held_in         = 1'b0;
            count_in           = '0;
         end else begin
            count_in = count_sat(count_ff);
            if (cr_held_ff) begin
               // released cr goes out first as field data
               push.valid0       = 1'b1;
               push.item0.data   = CHAR_CR;
               push.item0.role   = r1.role;
               push.item0.status = ST_PROGRESS;
               push.item0.last   = (req_tdata == CHAR_CR);
               pst_in            = r1.st;
               if (req_tdata != CHAR_CR) begin
                  push.valid1       = 1'b1;
                  push.item1.data   = req_tdata;
                  push.item1.role   = r2.role;
                  push.item1.status = ST_PROGRESS;
                  push.item1.last   = 1'b1;
                  pst_in            = r2.st;
                  cr_held_in        = 1'b0;
               end
            end else if (req_tdata == CHAR_CR) begin
               cr_held_in = 1'b1;
            end else begin
               push.valid0       = 1'b1;
               push.item0.data   = req_tdata;
               push.item0.role   = r2.role;
               push.item0.status = ST_PROGRESS;
               push.item0.last   = 1'b1;
               pst_in            = r2.st;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pst_ff     <= PARSE_RESET;
         cr_held_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         pst_ff     <= pst_in;
         cr_held_ff <= cr_held_in;
         count_ff   <= count_in;
      end
   end

   hrlp_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .free_two (req_tready),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_item  (rsp_item)
   );

   assign rsp_tdata = {6'd0, rsp_item.length, rsp_item.status, rsp_item.data};
   assign rsp_tuser = {rsp_item.done, rsp_item.role};
   assign rsp_tlast = rsp_item.last;

endmodule
`default_nettype wire

>>> sim/request_line_checker.sv
// checker for the request line parser: watches the byte, result and csr channels,
// tracks the parse state of each line and compares every result item in order
// depends on hrlp_pkg
`timescale 1ns / 1ps
module request_line_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [7:0]                       req_tdata,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [31:0]                      rsp_tdata,
   input  wire logic [3:0]                       rsp_tuser,
   input  wire logic                             rsp_tlast,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [hrlp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [hrlp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  wire logic                             csr_pready,
   output int                                    fail_count,
   output int                                    tags_pending
);
   import hrlp_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      role_type   role;
      logic       done;
      status_type status;
      len_type    length;
      logic       last;
   } byte_tag_type;

   localparam logic [39:0] VERSION_PREFIX = "HTTP/";

   byte_tag_type tag_queue[$];
   int           result_no;

   phase_type  phase;
   logic       field_empty;
   logic       query_seen;
   logic       bad_seen;
   vlen_type   version_len;
   logic       shape_ok;
   digit_type  ver_major;
   digit_type  ver_minor;
   logic       cr_held;
   count_type  line_count;

   digit_type  major_cfg;
   digit_type  cur_minor_cfg;
   digit_type  leg_minor_cfg;

   function automatic void rearm_line();
      phase       = PH_METHOD;
      field_empty = 1'b1;
      query_seen  = 1'b0;
      bad_seen    = 1'b0;
      version_len = '0;
      shape_ok    = 1'b1;
      ver_major   = '0;
      ver_minor   = '0;
      cr_held     = 1'b0;
      line_count  = '0;
   endfunction

   function automatic logic decimal(input logic [7:0] c);
      return c >= CHAR_0 && c <= CHAR_9;
   endfunction

   function automatic role_type tag_field_byte(input logic [7:0] c);
      role_type role;
      int       pos;
      role = ROLE_VERSION;
      pos  = int'(version_len);
      case (phase)
         PH_METHOD: begin
            if (c == CHAR_SPACE) begin
               if (field_empty) bad_seen = 1'b1;
               phase       = PH_TARGET;
               field_empty = 1'b1;
               role        = ROLE_SPACE;
            end else begin
               if (c < CHAR_A || c > CHAR_Z) bad_seen = 1'b1;
               field_empty = 1'b0;
               role        = ROLE_METHOD;
            end
         end
         PH_TARGET: begin
            if (c == CHAR_SPACE) begin
               if (field_empty) bad_seen = 1'b1;
               phase       = PH_VERSION;
               field_empty = 1'b1;
               role        = ROLE_SPACE;
            end else begin
               if (field_empty && c != CHAR_SLASH) bad_seen = 1'b1;
               field_empty = 1'b0;
               if (!query_seen && c == CHAR_QMARK) begin
                  query_seen = 1'b1;
                  role       = ROLE_QMARK;
               end else begin
                  role = query_seen ? ROLE_QUERY : ROLE_PATH;
               end
            end
         end
         default: begin
            if (c == CHAR_SPACE) begin
               bad_seen = 1'b1;
               role     = ROLE_SPACE;
            end
            if (pos < 5) begin
               if (c != VERSION_PREFIX[8*(4-pos) +: 8]) shape_ok = 1'b0;
            end else if (pos == 5) begin
               if (decimal(c)) ver_major = digit_type'(c - CHAR_0);
               else shape_ok = 1'b0;
            end else if (pos == 6) begin
               if (c != CHAR_DOT) shape_ok = 1'b0;
            end else if (pos == 7) begin
               if (decimal(c)) ver_minor = digit_type'(c - CHAR_0);
               else shape_ok = 1'b0;
            end else begin
               shape_ok = 1'b0;
            end
            if (version_len != VLEN_MAX) version_len = version_len + 1'b1;
            field_empty = 1'b0;
         end
      endcase
      return role;
   endfunction

   function automatic status_type judge_line();
      if (phase == PH_METHOD || phase == PH_TARGET || bad_seen) return ST_BAD;
      if (version_len != VERSION_LEN || !shape_ok) return ST_BAD;
      if (ver_major == major_cfg && (ver_minor == cur_minor_cfg || ver_minor == leg_minor_cfg))
         return ST_OK;
      return ST_UNSUPPORTED;
   endfunction

   function automatic void push_tag(input logic [7:0] data, input role_type role,
                                    input logic done, input status_type status,
                                    input len_type length);
      byte_tag_type t;
      t.data   = data;
      t.role   = role;
      t.done   = done;
      t.status = status;
      t.length = length;
      t.last   = 1'b0;
      tag_queue.push_back(t);
   endfunction

   function automatic void bump_count();
      if (line_count != '1) line_count = line_count + 1'b1;
   endfunction

   task automatic predict_byte(input logic [7:0] c);
      int      made;
      len_type length;
      made = 0;
      if (cr_held) begin
         cr_held = 1'b0;
         if (c == CHAR_LF) begin
            bump_count();
            length = (longint'(line_count) > longint'(LEN_MAX)) ? LEN_MAX
                                                                 : len_type'(line_count);
            push_tag(c, ROLE_END, 1'b1, judge_line(), length);
            tag_queue[tag_queue.size()-1].last = 1'b1;
            rearm_line();
            return;
         end
         // the held CR was counted when it came in
         push_tag(CHAR_CR, tag_field_byte(CHAR_CR), 1'b0, ST_PROGRESS, '0);
         made++;
      end
      bump_count();
      if (c == CHAR_CR) begin
         cr_held = 1'b1;
      end else begin
         push_tag(c, tag_field_byte(c), 1'b0, ST_PROGRESS, '0);
         made++;
      end
      if (made > 0) tag_queue[tag_queue.size()-1].last = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input int got_value,
                                  input int want_value);
      $display("result item %0d: %s is %0h, expected %0h", result_no, what, got_value,
               want_value);
      fail_count++;
   endtask

   task automatic check_result();
      byte_tag_type got;
      byte_tag_type want;
      got.data   = rsp_tdata[7:0];
      got.status = status_type'(rsp_tdata[9:8]);
      got.length = rsp_tdata[25:10];
      got.role   = role_type'(rsp_tuser[2:0]);
      got.done   = rsp_tuser[3];
      got.last   = rsp_tlast;
      if (tag_queue.size() == 0) begin
         report_mismatch("unexpected item, out_byte", int'(got.data), 0);
      end else begin
         want = tag_queue.pop_front();
         if (got.data != want.data)
            report_mismatch("out_byte", int'(got.data), int'(want.data));
         if (got.role != want.role)
            report_mismatch("byte_role", int'(got.role), int'(want.role));
         if (got.done != want.done)
            report_mismatch("line_done", int'(got.done), int'(want.done));
         if (got.status != want.status)
            report_mismatch("line_status", int'(got.status), int'(want.status));
         if (got.length != want.length)
            report_mismatch("line_length", int'(got.length), int'(want.length));
         if (got.last != want.last)
            report_mismatch("last_of_run", int'(got.last), int'(want.last));
      end
      result_no++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rearm_line();
         major_cfg     = digit_type'(1);
         cur_minor_cfg = digit_type'(1);
         leg_minor_cfg = digit_type'(0);
         tag_queue.delete();
         result_no  = 0;
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               CSR_MAJOR:     major_cfg     = csr_pwdata[DIGIT_WIDTH-1:0];
               CSR_CUR_MINOR: cur_minor_cfg = csr_pwdata[DIGIT_WIDTH-1:0];
               CSR_LEG_MINOR: leg_minor_cfg = csr_pwdata[DIGIT_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      tags_pending = tag_queue.size();
   end

endmodule

>>> sim/http_request_line_parser_test.sv
// testbench top for http_request_line_parser: drives request bytes and csr writes,
// stalls the result channel, and gives the verdict from request_line_checker
// depends on hrlp_pkg, request_line_checker and the parser rtl
`timescale 1ns / 1ps
module http_request_line_parser_test;
   import hrlp_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [31:0]            rsp_tdata;
   logic [3:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int          fail_count;
   int          tags_pending;
   int          cycle_count;
   int          hold_asks;
   int          bytes_sent;
   logic [7:0]  line_bytes[$];
   digit_type   major_now;
   digit_type   cur_now;
   digit_type   leg_now;
   logic        calm;

   // no random idling in the calm window set by cycle_count
   assign calm = (cycle_count % 1000) >= 700;

   http_request_line_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   request_line_checker line_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .fail_count   (fail_count),
      .tags_pending (tags_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      #200_000;
      $display("Some tests failed");
      $finish;
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      int hold_left;
      int served;
      hold_left = 0;
      served    = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != served) begin
            served    = hold_asks;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 7;
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input digit_type value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom();
      word[DIGIT_WIDTH-1:0] = value;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_digits(input digit_type major, input digit_type cur,
                             input digit_type leg);
      major_now = major;
      cur_now   = cur;
      leg_now   = leg;
      csr_write(CSR_MAJOR, major);
      csr_write(CSR_CUR_MINOR, cur);
      csr_write(CSR_LEG_MINOR, leg);
   endtask

   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
      line_bytes.delete();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tags_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void add_byte(input logic [7:0] b);
      line_bytes.push_back(b);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endfunction

   function automatic void add_crlf();
      line_bytes.push_back(CHAR_CR);
      line_bytes.push_back(CHAR_LF);
   endfunction

   // mostly one of the configured digits so that ok and unsupported both show up
   function automatic logic [7:0] digit_char(input digit_type a, input digit_type b);
      int        pick;
      digit_type d;
      pick = $urandom_range(99);
      if (pick < 40) d = a;
      else if (pick < 70) d = b;
      else d = digit_type'($urandom_range(9));
      if (d > 9) d = digit_type'($urandom_range(9));
      return CHAR_0 + d;
   endfunction

   task automatic build_request();
      string path_chars;
      int    n;
      int    pos;
      path_chars = "abcxyz019/-_.=&%?~";
      n = $urandom_range(99) < 4 ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) add_byte(8'(CHAR_A + $urandom_range(25)));
      add_byte(CHAR_SPACE);
      add_byte($urandom_range(99) < 5 ? path_chars[$urandom_range(path_chars.len()-1)]
                                      : CHAR_SLASH);
      n = $urandom_range(10);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 3) add_byte(8'($urandom_range(8'h21, 8'h7e)));
         else add_byte(path_chars[$urandom_range(path_chars.len()-1)]);
      end
      add_byte(CHAR_SPACE);
      add_text("HTTP/");
      add_byte(digit_char(major_now, major_now));
      add_byte(CHAR_DOT);
      if ($urandom_range(99) >= 5) add_byte(digit_char(cur_now, leg_now));
      if ($urandom_range(99) < 5) add_byte(8'(CHAR_0 + $urandom_range(9)));
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 2)) begin
            pos = $urandom_range(line_bytes.size()-1);
            case ($urandom_range(3))
               0: line_bytes[pos] = 8'($urandom_range(255));
               1: line_bytes.insert(pos, CHAR_CR);
               2: line_bytes.insert(pos, CHAR_SPACE);
               default: if (line_bytes.size() > 1) line_bytes.delete(pos);
            endcase
         end
      end
      if ($urandom_range(99) < 3) add_byte(CHAR_CR);
      add_crlf();
   endtask

   task automatic build_noise();
      int n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(7))
            0: add_byte(CHAR_SPACE);
            1: add_byte(CHAR_CR);
            2: add_byte(CHAR_LF);
            default: add_byte(8'($urandom_range(255)));
         endcase
      end
      if ($urandom_range(99) < 80) add_crlf();
   endtask

   initial begin
      int target;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_digits(digit_type'(1), digit_type'(1), digit_type'(0));
      add_text("GET / HTTP/1.1");
      add_crlf();
      // empty method, target opening with '?', released cr in the query
      add_text(" ?");
      add_byte(CHAR_CR);
      add_byte(CHAR_SPACE);
      add_crlf();
      // bad method bytes, released cr in the method, no spaces at all
      add_byte(8'hFF);
      add_byte(8'h00);
      add_byte(CHAR_CR);
      add_crlf();
      send_line();
      wait_drained();

      target = 0;
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: set_digits(digit_type'(1), digit_type'(1), digit_type'(0));
            1: set_digits(digit_type'(0), digit_type'(0), digit_type'(9));
            2: set_digits(digit_type'(9), digit_type'(0), digit_type'(9));
            3: set_digits(digit_type'(15), digit_type'(15), digit_type'(10));
            default: set_digits(digit_type'($urandom_range(9)),
                                digit_type'($urandom_range(9)),
                                digit_type'($urandom_range(9)));
         endcase
         if (p == 1) hold_asks++;
         target = bytes_sent + 150;
         while (bytes_sent < target) begin
            if ($urandom_range(99) < 80) build_request();
            else build_noise();
            send_line();
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
